// ===== src/barycentric_coordinates_defines.svh =====
// Assertion macros for the barycentric coordinates block.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef BARYCENTRIC_COORDINATES_DEFINES_SVH
`define BARYCENTRIC_COORDINATES_DEFINES_SVH

// same-cycle implication, held off during reset
`define BC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define BC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bc_pkg.sv =====
// Shared widths and defaults for the barycentric coordinates block.
// No dependencies; used by the channel interfaces and the top level.
package bc_pkg;
    localparam int COORD_W       = 12;
    localparam int WEIGHT_W      = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int DOT_W         = PROD_W + 2;
    localparam int PROD2_W       = 2 * DOT_W;
    localparam int NUM_W         = PROD2_W + 1;
endpackage

// ===== src/bc_query_if.sv =====
// Query channel: point and triangle corners, valid/ready handshake.
// Depends on bc_pkg for the coordinate width.
interface bc_query_if;
    logic valid;
    logic ready;
    logic signed [bc_pkg::COORD_W-1:0] point_x;
    logic signed [bc_pkg::COORD_W-1:0] point_y;
    logic signed [bc_pkg::COORD_W-1:0] point_z;
    logic signed [bc_pkg::COORD_W-1:0] corner_a_x;
    logic signed [bc_pkg::COORD_W-1:0] corner_a_y;
    logic signed [bc_pkg::COORD_W-1:0] corner_a_z;
    logic signed [bc_pkg::COORD_W-1:0] corner_b_x;
    logic signed [bc_pkg::COORD_W-1:0] corner_b_y;
    logic signed [bc_pkg::COORD_W-1:0] corner_b_z;
    logic signed [bc_pkg::COORD_W-1:0] corner_c_x;
    logic signed [bc_pkg::COORD_W-1:0] corner_c_y;
    logic signed [bc_pkg::COORD_W-1:0] corner_c_z;

    modport source (output valid, point_x, point_y, point_z, corner_a_x, corner_a_y,
                    corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x,
                    corner_c_y, corner_c_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, corner_a_x, corner_a_y,
                  corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x,
                  corner_c_y, corner_c_z, output ready);
endinterface

// ===== src/bc_result_if.sv =====
// Result channel: three fixed-point weights and the degenerate flag.
// Depends on bc_pkg for the weight width.
interface bc_result_if;
    logic valid;
    logic ready;
    logic signed [bc_pkg::WEIGHT_W-1:0] weight_u;
    logic signed [bc_pkg::WEIGHT_W-1:0] weight_v;
    logic signed [bc_pkg::WEIGHT_W-1:0] weight_w;
    logic degenerate;

    modport source (output valid, weight_u, weight_v, weight_w, degenerate, input ready);
    modport sink (input valid, weight_u, weight_v, weight_w, degenerate, output ready);
endinterface

// ===== src/barycentric_coordinates.sv =====
// Barycentric coordinates of a point in a triangle, fully pipelined.
// Depends on bc_pkg, bc_query_if, bc_result_if and the defines header.
//
// Usage:
//   query  (sink)  : point p and corners a, b, c, 12-bit signed each.
//   result (source): weight_u/v/w as signed fixed point with FRAC_BITS
//                    fraction bits, saturated to 32 bits, plus degenerate.
//   A beat moves when valid and ready are both high.
// Pipeline: 7 arithmetic stages, 32 restoring divide stages, one bit of quotient
//   each, and 2 output stages.
// Throughput: one query per cycle while the result side does not stall; set by
//   the divide pipeline, which retires one full quotient per cycle for each of v and w.
// Stall: each stage holds while its successor is full and stalled; bubbles
//   close up, so queries are still taken while a result waits, until every
//   stage is full. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits; the pipe is empty afterwards.
// Degenerate triangles (zero Gram determinant) give all weights zero.
`include "barycentric_coordinates_defines.svh"

module barycentric_coordinates #(
    parameter int FRAC_BITS = bc_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bc_query_if.sink     query,
    bc_result_if.source  result
);
    localparam int DIFF_W  = bc_pkg::DIFF_W;
    localparam int PROD_W  = bc_pkg::PROD_W;
    localparam int DOT_W   = bc_pkg::DOT_W;
    localparam int PROD2_W = bc_pkg::PROD2_W;
    localparam int NUM_W   = bc_pkg::NUM_W;
    localparam int Q_W     = bc_pkg::WEIGHT_W;
    localparam int R_W     = NUM_W + Q_W;
    localparam int SUM_W   = Q_W + 2;

    localparam int ST_DIV0 = 7;
    localparam int ST_VW   = ST_DIV0 + Q_W;
    localparam int ST_U    = ST_VW + 1;
    localparam int NSTG    = ST_U + 1;

    localparam logic signed [Q_W-1:0] W_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] W_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic [R_W-1:0]   rem_v;
        logic [R_W-1:0]   rem_w;
        logic [Q_W-1:0]   q_v;
        logic [Q_W-1:0]   q_w;
        logic [NUM_W-1:0] den;
        logic             neg_v;
        logic             neg_w;
        logic             sat_v;
        logic             sat_w;
        logic             degen;
    } div_t;

    // ---------------- handshake chain ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    assign adv[NSTG] = result.ready;
    genvar gi;
    generate
        for (gi = 0; gi < NSTG; gi++)
        begin : g_adv
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
        end
    endgenerate

    assign query.ready  = adv[0];
    assign result.valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= (i == 0) ? query.valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // ---------------- stage 0: edge vectors ----------------
    logic signed [DIFF_W-1:0] e_reg [9];
    logic signed [DIFF_W-1:0] e_next [9];

    always_comb
    begin
        e_next[0] = DIFF_W'(query.corner_b_x) - DIFF_W'(query.corner_a_x);
        e_next[1] = DIFF_W'(query.corner_b_y) - DIFF_W'(query.corner_a_y);
        e_next[2] = DIFF_W'(query.corner_b_z) - DIFF_W'(query.corner_a_z);
        e_next[3] = DIFF_W'(query.corner_c_x) - DIFF_W'(query.corner_a_x);
        e_next[4] = DIFF_W'(query.corner_c_y) - DIFF_W'(query.corner_a_y);
        e_next[5] = DIFF_W'(query.corner_c_z) - DIFF_W'(query.corner_a_z);
        e_next[6] = DIFF_W'(query.point_x) - DIFF_W'(query.corner_a_x);
        e_next[7] = DIFF_W'(query.point_y) - DIFF_W'(query.corner_a_y);
        e_next[8] = DIFF_W'(query.point_z) - DIFF_W'(query.corner_a_z);
    end

    // ---------------- stage 1: component products ----------------
    // rows: d00, d01, d11, d20, d21; three components each
    logic signed [PROD_W-1:0] m_reg [15];
    logic signed [PROD_W-1:0] m_next [15];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m_next[k]      = PROD_W'(e_reg[k]) * PROD_W'(e_reg[k]);
            m_next[3 + k]  = PROD_W'(e_reg[k]) * PROD_W'(e_reg[3 + k]);
            m_next[6 + k]  = PROD_W'(e_reg[3 + k]) * PROD_W'(e_reg[3 + k]);
            m_next[9 + k]  = PROD_W'(e_reg[6 + k]) * PROD_W'(e_reg[k]);
            m_next[12 + k] = PROD_W'(e_reg[6 + k]) * PROD_W'(e_reg[3 + k]);
        end
    end

    // ---------------- stage 2: dot products ----------------
    logic signed [DOT_W-1:0] d_reg [5];
    logic signed [DOT_W-1:0] d_next [5];

    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            d_next[j] = DOT_W'(m_reg[3*j]) + DOT_W'(m_reg[3*j + 1]) + DOT_W'(m_reg[3*j + 2]);
        end
    end

    // ---------------- stage 3: second-order products ----------------
    // d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
    logic signed [PROD2_W-1:0] p_reg [6];
    logic signed [PROD2_W-1:0] p_next [6];

    always_comb
    begin
        p_next[0] = PROD2_W'(d_reg[0]) * PROD2_W'(d_reg[2]);
        p_next[1] = PROD2_W'(d_reg[1]) * PROD2_W'(d_reg[1]);
        p_next[2] = PROD2_W'(d_reg[2]) * PROD2_W'(d_reg[3]);
        p_next[3] = PROD2_W'(d_reg[1]) * PROD2_W'(d_reg[4]);
        p_next[4] = PROD2_W'(d_reg[0]) * PROD2_W'(d_reg[4]);
        p_next[5] = PROD2_W'(d_reg[1]) * PROD2_W'(d_reg[3]);
    end

    // ---------------- stage 4: determinant and numerators ----------------
    logic signed [NUM_W-1:0] den_reg, nv_reg, nw_reg;
    logic signed [NUM_W-1:0] den_next, nv_next, nw_next;

    assign den_next = NUM_W'(p_reg[0]) - NUM_W'(p_reg[1]);
    assign nv_next  = NUM_W'(p_reg[2]) - NUM_W'(p_reg[3]);
    assign nw_next  = NUM_W'(p_reg[4]) - NUM_W'(p_reg[5]);

    // ---------------- stage 5: sign and magnitude ----------------
    logic [NUM_W-1:0] a_den_reg, a_mv_reg, a_mw_reg;
    logic             a_nv_reg, a_nw_reg, a_dg_reg;
    logic [NUM_W-1:0] a_mv_next, a_mw_next;
    logic             a_dg_next;

    assign a_mv_next = nv_reg[NUM_W-1] ? NUM_W'(-nv_reg) : NUM_W'(nv_reg);
    assign a_mw_next = nw_reg[NUM_W-1] ? NUM_W'(-nw_reg) : NUM_W'(nw_reg);
    assign a_dg_next = den_reg[NUM_W-1] || (den_reg == '0);

    // ---------------- stage 6: scale and overflow check ----------------
    div_t dv_reg  [Q_W+1];
    div_t dv_next [Q_W+1];

    always_comb
    begin
        logic [R_W-1:0] den_hi;
        den_hi            = {a_den_reg, {Q_W{1'b0}}};
        dv_next[0].rem_v  = R_W'(a_mv_reg) << FRAC_BITS;
        dv_next[0].rem_w  = R_W'(a_mw_reg) << FRAC_BITS;
        // quotient would need 33 or more bits: saturate
        dv_next[0].sat_v  = (R_W'(a_mv_reg) << FRAC_BITS) >= den_hi;
        dv_next[0].sat_w  = (R_W'(a_mw_reg) << FRAC_BITS) >= den_hi;
        dv_next[0].q_v    = '0;
        dv_next[0].q_w    = '0;
        dv_next[0].den    = a_den_reg;
        dv_next[0].neg_v  = a_nv_reg;
        dv_next[0].neg_w  = a_nw_reg;
        dv_next[0].degen  = a_dg_reg;
    end

    // ---------------- divide stages: one quotient bit each ----------------
    generate
        for (gi = 0; gi < Q_W; gi++)
        begin : g_div
            localparam int SH = Q_W - 1 - gi;
            logic [R_W:0] dif_v, dif_w, dsh;

            always_comb
            begin
                dsh   = (R_W+1)'(dv_reg[gi].den) << SH;
                dif_v = {1'b0, dv_reg[gi].rem_v} - dsh;
                dif_w = {1'b0, dv_reg[gi].rem_w} - dsh;
                dv_next[gi+1]       = dv_reg[gi];
                dv_next[gi+1].q_v   = {dv_reg[gi].q_v[Q_W-2:0], !dif_v[R_W]};
                dv_next[gi+1].q_w   = {dv_reg[gi].q_w[Q_W-2:0], !dif_w[R_W]};
                if (!dif_v[R_W])
                begin
                    dv_next[gi+1].rem_v = dif_v[R_W-1:0];
                end
                if (!dif_w[R_W])
                begin
                    dv_next[gi+1].rem_w = dif_w[R_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[ST_DIV0 + gi])
                begin
                    dv_reg[gi+1] <= dv_next[gi+1];
                end
            end
        end
    endgenerate

    // ---------------- stage v/w: sign and saturation ----------------
    function automatic logic signed [Q_W-1:0] fin(input logic [Q_W-1:0] q, input logic neg,
                                                  input logic sat, input logic dg);
        logic signed [Q_W-1:0] r;
        if (dg)
        begin
            r = '0;
        end
        else if (neg)
        begin
            r = (sat || (q > W_MIN)) ? W_MIN : -q;
        end
        else
        begin
            r = (sat || (q > W_MAX)) ? W_MAX : q;
        end
        return r;
    endfunction

    logic signed [Q_W-1:0] v_reg, w_reg;
    logic                  vw_dg_reg;
    logic signed [Q_W-1:0] v_next, w_next;

    assign v_next = fin(dv_reg[Q_W].q_v, dv_reg[Q_W].neg_v, dv_reg[Q_W].sat_v,
                        dv_reg[Q_W].degen);
    assign w_next = fin(dv_reg[Q_W].q_w, dv_reg[Q_W].neg_w, dv_reg[Q_W].sat_w,
                        dv_reg[Q_W].degen);

    // ---------------- stage u: one minus v minus w ----------------
    logic signed [SUM_W-1:0] u_wide;
    logic signed [Q_W-1:0]   u_next;
    logic signed [Q_W-1:0]   o_u_reg, o_v_reg, o_w_reg;
    logic                    o_dg_reg;

    always_comb
    begin
        u_wide = (SUM_W'(1) <<< FRAC_BITS) - SUM_W'(v_reg) - SUM_W'(w_reg);
        if (vw_dg_reg)
        begin
            u_next = '0;
        end
        else if (u_wide > SUM_W'(W_MAX))
        begin
            u_next = W_MAX;
        end
        else if (u_wide < SUM_W'(W_MIN))
        begin
            u_next = W_MIN;
        end
        else
        begin
            u_next = u_wide[Q_W-1:0];
        end
    end

    assign result.weight_u   = o_u_reg;
    assign result.weight_v   = o_v_reg;
    assign result.weight_w   = o_w_reg;
    assign result.degenerate = o_dg_reg;

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e_reg <= e_next;
        end
        if (adv[1])
        begin
            m_reg <= m_next;
        end
        if (adv[2])
        begin
            d_reg <= d_next;
        end
        if (adv[3])
        begin
            p_reg <= p_next;
        end
        if (adv[4])
        begin
            den_reg <= den_next;
            nv_reg  <= nv_next;
            nw_reg  <= nw_next;
        end
        if (adv[5])
        begin
            a_den_reg <= den_reg;
            a_mv_reg  <= a_mv_next;
            a_mw_reg  <= a_mw_next;
            a_nv_reg  <= nv_reg[NUM_W-1];
            a_nw_reg  <= nw_reg[NUM_W-1];
            a_dg_reg  <= a_dg_next;
        end
        if (adv[6])
        begin
            dv_reg[0] <= dv_next[0];
        end
        if (adv[ST_VW])
        begin
            v_reg     <= v_next;
            w_reg     <= w_next;
            vw_dg_reg <= dv_reg[Q_W].degen;
        end
        if (adv[ST_U])
        begin
            o_u_reg  <= u_next;
            o_v_reg  <= v_reg;
            o_w_reg  <= w_reg;
            o_dg_reg <= vw_dg_reg;
        end
    end

    // ---------------- assertions ----------------
    logic signed [SUM_W-1:0] chk_sum;
    logic                    chk_unsat;

    assign chk_sum = SUM_W'(o_u_reg) + SUM_W'(o_v_reg) + SUM_W'(o_w_reg);
    assign chk_unsat = (o_u_reg != W_MAX) && (o_u_reg != W_MIN) &&
                       (o_v_reg != W_MAX) && (o_v_reg != W_MIN) &&
                       (o_w_reg != W_MAX) && (o_w_reg != W_MIN);

    `BC_ASSERT_IMPL(a_degen_zero, result.valid && result.degenerate,
        (result.weight_u == '0) && (result.weight_v == '0) && (result.weight_w == '0),
        "degenerate result with nonzero weight")
    `BC_ASSERT_IMPL(a_weight_sum, result.valid && !result.degenerate && chk_unsat,
        chk_sum == (SUM_W'(1) <<< FRAC_BITS), "unsaturated weights do not sum to one")
    `BC_ASSERT_IMPL(a_full_stall, !query.ready,
        (&vld_reg) && !result.ready, "query refused while the pipe has room")
    `BC_ASSERT_NEXT(a_take_lands, query.valid && query.ready, vld_reg[0],
        "accepted query missing from first stage")
endmodule

// ===== sim/bc_tb_channels.sv =====
`timescale 1ns / 1ps
// Testbench-side copies of the query and result channels.
// Depends on bc_pkg; the block's own interfaces are used for the DUT ports.
package bc_tb_types;
    typedef struct packed {
        logic signed [bc_pkg::COORD_W-1:0] px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
    } query_t;
    typedef struct packed {
        logic signed [bc_pkg::WEIGHT_W-1:0] u, v, w;
        logic                                degen;
    } weights_t;
endpackage

// ===== sim/barycentric_coordinates_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for barycentric_coordinates: directed table, then random
// triangles, checked against a fixed-point weight predictor. Depends on bc_pkg, the interfaces.
module barycentric_coordinates_tb;

    localparam int FRAC      = bc_pkg::FRAC_BITS_DEF;
    localparam int CW        = bc_pkg::COORD_W;
    localparam int LATENCY   = 41;
    localparam int WATCHDOG  = 20000;
    localparam longint WMAX  = 64'sd2147483647;
    localparam longint WMIN  = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    bc_query_if  query();
    bc_result_if result();

    barycentric_coordinates dut (.clk(clk), .rst_n(rst_n), .query(query), .result(result));

    bc_tb_types::weights_t expected_weights[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    typedef struct {
        bc_tb_types::query_t   q;
        bit                    typed;
        bc_tb_types::weights_t w;
    } row_t;

    function automatic longint weight_div(longint num, longint den);
        bit neg;
        longint mag, ip, r, q;
        neg = num < 0;
        mag = neg ? -num : num;
        ip = mag / den;
        r = mag % den;
        if (ip >= 64'sd4294967296)
            return neg ? WMIN : WMAX;
        q = ip;
        for (int i = 0; i < FRAC; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        if (neg)
            return (q > 64'sd2147483648) ? WMIN : -q;
        return (q > WMAX) ? WMAX : q;
    endfunction

    function automatic bc_tb_types::weights_t bary_weights(bc_tb_types::query_t q);
        longint e0[3], e1[3], e2[3];
        longint d00, d01, d11, d20, d21, den, v, w, u;
        bc_tb_types::weights_t r;
        e0 = '{longint'(q.bx) - q.ax, longint'(q.by) - q.ay, longint'(q.bz) - q.az};
        e1 = '{longint'(q.cx) - q.ax, longint'(q.cy) - q.ay, longint'(q.cz) - q.az};
        e2 = '{longint'(q.px) - q.ax, longint'(q.py) - q.ay, longint'(q.pz) - q.az};
        d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
        for (int k = 0; k < 3; k++)
        begin
            d00 += e0[k] * e0[k];
            d01 += e0[k] * e1[k];
            d11 += e1[k] * e1[k];
            d20 += e2[k] * e0[k];
            d21 += e2[k] * e1[k];
        end
        den = d00 * d11 - d01 * d01;
        r = '0;
        if (den <= 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        v = weight_div(d11 * d20 - d01 * d21, den);
        w = weight_div(d00 * d21 - d01 * d20, den);
        u = (longint'(1) << FRAC) - v - w;
        if (u > WMAX) u = WMAX;
        if (u < WMIN) u = WMIN;
        r.u = u[31:0];
        r.v = v[31:0];
        r.w = w[31:0];
        return r;
    endfunction

    function automatic bc_tb_types::query_t tri_q(int px, int py, int pz, int ax, int ay,
                                                  int az, int bx, int by, int bz, int cx,
                                                  int cy, int cz);
        bc_tb_types::query_t q;
        q = '{CW'(px), CW'(py), CW'(pz), CW'(ax), CW'(ay), CW'(az),
              CW'(bx), CW'(by), CW'(bz), CW'(cx), CW'(cy), CW'(cz)};
        return q;
    endfunction

    // base plus a uniform offset in [-span, span], wrapped to the coordinate width
    function automatic logic signed [CW-1:0] jitter(logic signed [CW-1:0] base, int span);
        return CW'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic bc_tb_types::query_t random_query();
        bc_tb_types::query_t q;
        logic [159:0] rnd;
        int span;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
        q = bc_tb_types::query_t'(rnd[$bits(bc_tb_types::query_t)-1:0]);
        case ($urandom_range(0, 5))
            0: ;
            1:
            begin
                // small, local triangle around a random origin
                span = 1 << $urandom_range(1, 8);
                q.bx = jitter(q.ax, span);
                q.by = jitter(q.ay, span);
                q.bz = jitter(q.az, span);
                q.cx = jitter(q.ax, span);
                q.cy = jitter(q.ay, span);
                q.cz = jitter(q.az, span);
            end
            2:
            begin
                // collinear corners: c = a + k*(b - a)
                q.cx = CW'(2 * int'(q.bx) - int'(q.ax));
                q.cy = CW'(2 * int'(q.by) - int'(q.ay));
                q.cz = CW'(2 * int'(q.bz) - int'(q.az));
                if ($urandom_range(0, 1)) q.cx = q.ax;
                if (q.cx == q.ax)
                begin
                    q.cy = q.ay;
                    q.cz = q.az;
                end
            end
            3:
            begin
                // point at corner b
                q.px = q.bx; q.py = q.by; q.pz = q.bz;
            end
            4:
            begin
                // nearly flat triangle: huge weights, saturation
                q.ax = '0; q.ay = '0; q.az = '0;
                q.bx = CW'(2047); q.by = '0; q.bz = '0;
                q.cx = CW'(-2048); q.cy = $urandom_range(0, 1) ? CW'(1) : CW'(-1); q.cz = '0;
            end
            default:
            begin
                q.px = jitter(q.ax, 32);
            end
        endcase
        return q;
    endfunction

    // receiver side: stall and check
    always @(negedge clk)
        result.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        bc_tb_types::weights_t exp_w, got;
        if (query.valid && query.ready)
            idle_cycles <= 0;
        else if (!(result.valid && result.ready))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.weight_u, result.weight_v, result.weight_w, result.degenerate};
            if (expected_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat u=%0d v=%0d w=%0d degen=%0b",
                             got.u, got.v, got.w, got.degen);
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                if (got !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp u=%0d v=%0d w=%0d dg=%0b, got %0d %0d %0d %0b",
                                 exp_w.u, exp_w.v, exp_w.w, exp_w.degen,
                                 got.u, got.v, got.w, got.degen);
                end
            end
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_query(bc_tb_types::query_t q, bc_tb_types::weights_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            query.valid <= 1'b0;
            @(negedge clk);
        end
        {query.point_x, query.point_y, query.point_z, query.corner_a_x, query.corner_a_y,
         query.corner_a_z, query.corner_b_x, query.corner_b_y, query.corner_b_z,
         query.corner_c_x, query.corner_c_y, query.corner_c_z} <= q;
        query.valid <= 1'b1;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        expected_weights.push_back(w);
        @(negedge clk);
    endtask

    task automatic drain_results();
        query.valid <= 1'b0;
        while (expected_weights.size() != 0)
            @(negedge clk);
    endtask

    row_t directed[$];
    bc_tb_types::weights_t degen_w, corner_a_w;

    initial
    begin
        bc_tb_types::query_t q;
        bc_tb_types::weights_t w;
        query.valid = 1'b0;
        {query.point_x, query.point_y, query.point_z, query.corner_a_x, query.corner_a_y,
         query.corner_a_z, query.corner_b_x, query.corner_b_y, query.corner_b_z,
         query.corner_c_x, query.corner_c_y, query.corner_c_z} = '0;
        degen_w = '0;
        degen_w.degen = 1'b1;
        corner_a_w = '{32'sd65536, 32'sd0, 32'sd0, 1'b0};
        // typed rows: degenerate shapes and a point on each corner
        directed.push_back('{'0, 1'b1, degen_w});
        directed.push_back('{tri_q(5, 5, 5, 1, 2, 3, 1, 2, 3, 7, 8, 9), 1'b1, degen_w});
        directed.push_back('{tri_q(0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, degen_w});
        directed.push_back('{tri_q(-2048, -2048, -2048, -2048, -2048, -2048, 2047, 2047, 2047,
                                   -2048, -2048, -2048), 1'b1, degen_w});
        directed.push_back('{tri_q(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1, corner_a_w});
        directed.push_back('{tri_q(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1,
                             '{32'sd0, 32'sd65536, 32'sd0, 1'b0}});
        directed.push_back('{tri_q(0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1,
                             '{32'sd0, 32'sd0, 32'sd65536, 1'b0}});
        // predictor rows: extremes, outside points, saturation, negative weights
        directed.push_back('{tri_q(2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, -2048,
                                   -2048, 2047, -2048), 1'b0, '0});
        directed.push_back('{tri_q(-2048, 2047, -2048, 2047, -2048, 2047, -2048, -2048, 2047,
                                   2047, 2047, -2048), 1'b0, '0});
        directed.push_back('{tri_q(2047, 2047, 2047, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0});
        directed.push_back('{tri_q(-2048, -2048, -2048, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0});
        directed.push_back('{tri_q(0, 2047, 0, 0, 0, 0, 2047, 0, 0, -2048, 1, 0), 1'b0, '0});
        directed.push_back('{tri_q(0, -2048, 0, 0, 0, 0, 2047, 0, 0, -2048, 1, 0), 1'b0, '0});
        directed.push_back('{tri_q(1, 1, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0), 1'b0, '0});
        directed.push_back('{tri_q(-1, -1, -1, 0, 0, 0, 3, 0, 0, 0, 0, 7), 1'b0, '0});
        directed.push_back('{tri_q(100, -200, 300, 10, 20, 30, -500, 600, 70, 800, -90, -1000),
                             1'b0, '0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            w = bary_weights(directed[i].q);
            if (directed[i].typed && w !== directed[i].w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: predictor disagrees with typed weights", i);
            end
            send_query(directed[i].q, directed[i].typed ? directed[i].w : w);
        end
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 19 : 57) : 0;
            stall_pct     = (phase == 2 || phase == 3) ? ((phase == 3) ? 19 : 57) : 0;
            for (int n = 0; n < 410; n++)
            begin
                q = random_query();
                send_query(q, bary_weights(q));
                if (n == 200)
                    drain_results();
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
        drain_results();
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0 && expected_weights.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/bc_pkg.sv
src/bc_query_if.sv
src/bc_result_if.sv
src/barycentric_coordinates.sv
sim/bc_tb_channels.sv
sim/barycentric_coordinates_tb.sv
